>>> design/xaso_pkg.sv
`default_nettype none

package xaso_pkg;

  localparam int unsigned MaxParams  = 32;
  localparam int unsigned StackAlign = 4;

  localparam logic [2:0] ClsFloat     = 3'd0;
  localparam logic [2:0] ClsDouble    = 3'd1;
  localparam logic [2:0] ClsScalar    = 3'd2;
  localparam logic [2:0] ClsStructPtr = 3'd3;

  typedef enum logic [2:0] {
    StLoad,
    StWalk,
    StRdSlot,
    StRdOff,
    StLatch,
    StSend
  } state_e;

endpackage

`default_nettype wire

>>> design/xaso_ram.sv
`default_nettype none

module xaso_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> design/x86_arg_stack_offset_layout_unit.sv
`default_nettype none

// A record is taken in the load state; a record without the last mark gives no beat.
// On the last record, the slot walk adds one footprint per slot, from slot 0 to the highest slot,
// then each offset beat takes two RAM reads in series (slot RAM, then offset RAM) plus any output stall.
// A failed signature gives its single status beat on the cycle after the last record.
// Reset (async, active low) clears the sequencer, counters and per-slot width marks;
// the slot and offset RAMs are not cleared and need no clearing pass.
module x86_arg_stack_offset_layout_unit #(
  parameter int unsigned MaxRecords = xaso_pkg::MaxParams
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  param_class_i,
  input  wire logic [15:0] scalar_width_i,
  input  wire logic [7:0]  slot_i,
  input  wire logic        type_ends_in_star_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [7:0]  offset_o,
  output logic             status_o,
  output logic             last_result_o
);

  localparam int unsigned SlotW = $clog2(MaxRecords);
  localparam int unsigned CntW  = $clog2(MaxRecords + 1);
  localparam logic [8:0]      SlotLimit = 9'(MaxRecords);
  localparam logic [CntW-1:0] CntLimit  = CntW'(MaxRecords);

  xaso_pkg::state_e state_q, state_d;

  logic [CntW-1:0]       total_q;
  logic [SlotW-1:0]      highest_q;
  logic                  failed_q;
  logic [MaxRecords-1:0] wide_q;
  logic [SlotW-1:0]      walk_idx_q;
  logic [7:0]            running_q;
  logic [SlotW-1:0]      emit_idx_q;
  logic [7:0]            out_offset_q;
  logic                  out_status_q;
  logic                  out_last_q;

  logic             in_fire;
  logic             rec_bad;
  logic             rec_wide;
  logic             slot_ok;
  logic             load_ok;
  logic             fail_d;
  logic             emit_final;
  logic             slot_re;
  logic             off_re;
  logic             off_we;
  logic [SlotW-1:0] slot_rdata;
  logic [7:0]       off_rdata;
  logic [SlotW-1:0] slot_idx;

  assign in_fire  = in_valid_i && in_ready_o;
  assign slot_ok  = {1'b0, slot_i} < SlotLimit;
  assign slot_idx = slot_i[SlotW-1:0];

  always_comb begin
    rec_bad  = 1'b0;
    rec_wide = 1'b0;
    case (param_class_i)
      xaso_pkg::ClsFloat: begin
        rec_wide = 1'b0;
      end
      xaso_pkg::ClsDouble: begin
        rec_wide = 1'b1;
      end
      xaso_pkg::ClsScalar: begin
        rec_bad  = scalar_width_i == 16'd8;
        rec_wide = scalar_width_i >= 16'd5 && scalar_width_i <= 16'd7;
      end
      xaso_pkg::ClsStructPtr: begin
        rec_bad = !type_ends_in_star_i;
      end
      default: begin
        rec_wide = 1'b0;
      end
    endcase
  end

  assign load_ok = in_fire && !failed_q && total_q < CntLimit && slot_ok && !rec_bad;
  assign fail_d  = failed_q || (in_fire && !load_ok);
  assign emit_final = (CntW'(emit_idx_q) + CntW'(1)) == total_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      xaso_pkg::StLoad: begin
        if (in_fire && last_i) begin
          state_d = fail_d ? xaso_pkg::StSend : xaso_pkg::StWalk;
        end
      end
      xaso_pkg::StWalk: begin
        if (walk_idx_q == highest_q) begin
          state_d = xaso_pkg::StRdSlot;
        end
      end
      xaso_pkg::StRdSlot: state_d = xaso_pkg::StRdOff;
      xaso_pkg::StRdOff:  state_d = xaso_pkg::StLatch;
      xaso_pkg::StLatch:  state_d = xaso_pkg::StSend;
      xaso_pkg::StSend: begin
        if (out_ready_i) begin
          state_d = (out_status_q || emit_final) ? xaso_pkg::StLoad : xaso_pkg::StRdSlot;
        end
      end
      default: state_d = xaso_pkg::StLoad;
    endcase
  end

  always_comb begin
    in_ready_o  = state_q == xaso_pkg::StLoad;
    out_valid_o = state_q == xaso_pkg::StSend;
    off_we      = state_q == xaso_pkg::StWalk;
    slot_re     = state_q == xaso_pkg::StRdSlot;
    off_re      = state_q == xaso_pkg::StRdOff;
  end

  assign offset_o      = out_offset_q;
  assign status_o      = out_status_q;
  assign last_result_o = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= xaso_pkg::StLoad;
      total_q    <= '0;
      highest_q  <= '0;
      failed_q   <= 1'b0;
      wide_q     <= '0;
      walk_idx_q <= '0;
      running_q  <= '0;
      emit_idx_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        xaso_pkg::StLoad: begin
          if (load_ok) begin
            wide_q[slot_idx] <= rec_wide;
            total_q          <= total_q + CntW'(1);
            if (slot_idx > highest_q) begin
              highest_q <= slot_idx;
            end
          end
          if (in_fire) begin
            failed_q <= fail_d && !last_i;
            if (last_i && fail_d) begin
              total_q   <= '0;
              highest_q <= '0;
              wide_q    <= '0;
            end
          end
          walk_idx_q <= '0;
          running_q  <= '0;
          emit_idx_q <= '0;
        end
        xaso_pkg::StWalk: begin
          walk_idx_q <= walk_idx_q + SlotW'(1);
          running_q  <= running_q + (wide_q[walk_idx_q] ? 8'd8 : 8'(xaso_pkg::StackAlign));
        end
        xaso_pkg::StSend: begin
          if (out_ready_i) begin
            emit_idx_q <= emit_idx_q + SlotW'(1);
            if (!out_status_q && emit_final) begin
              total_q   <= '0;
              highest_q <= '0;
              failed_q  <= 1'b0;
              wide_q    <= '0;
            end
          end
        end
        default: begin
          emit_idx_q <= emit_idx_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == xaso_pkg::StLoad && in_fire && last_i && fail_d) begin
      out_offset_q <= '0;
      out_status_q <= 1'b1;
      out_last_q   <= 1'b1;
    end else if (state_q == xaso_pkg::StLatch) begin
      out_offset_q <= off_rdata;
      out_status_q <= 1'b0;
      out_last_q   <= emit_final;
    end
  end

  xaso_ram #(
    .Width(SlotW),
    .Depth(MaxRecords)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (load_ok),
    .waddr_i(total_q[SlotW-1:0]),
    .wdata_i(slot_idx),
    .re_i   (slot_re),
    .raddr_i(emit_idx_q),
    .rdata_o(slot_rdata)
  );

  xaso_ram #(
    .Width(8),
    .Depth(MaxRecords)
  ) u_offset_ram (
    .clk_i  (clk_i),
    .we_i   (off_we),
    .waddr_i(walk_idx_q),
    .wdata_i(running_q),
    .re_i   (off_re),
    .raddr_i(slot_rdata),
    .rdata_o(off_rdata)
  );

`ifndef NO_ASSERTIONS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output side active together");

  a_walk_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == xaso_pkg::StWalk |-> !failed_q && total_q != '0 && walk_idx_q <= highest_q)
    else $error("slot walk entered in a bad state");

  a_fail_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_status_q |-> out_last_q && out_offset_q == '0)
    else $error("status beat malformed");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_status_q |-> CntW'(emit_idx_q) < total_q)
    else $error("offset beat beyond record count");

  a_clear_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_last_q |=> total_q == '0 && !failed_q && wide_q == '0)
    else $error("signature state not cleared");
`endif

endmodule

`default_nettype wire

>>> tb/sv/x86_arg_stack_offset_layout_unit_test.sv
`timescale 1ns / 100ps

module x86_arg_stack_offset_layout_unit_test;

  localparam logic [2:0] ClsHandle = 3'd4;
  localparam logic [2:0] ClsSpare  = 3'd7;
  localparam int unsigned RandomRecords = 200;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned NumRows       = 21;

  typedef struct packed {
    logic [2:0]  cls;
    logic [15:0] width;
    logic [7:0]  slot;
    logic        star;
    logic        last;
  } record_t;

  typedef struct packed {
    logic [7:0] offset;
    logic       status;
    logic       last_result;
  } beat_t;

  typedef struct packed {
    record_t rec;
    logic    typed;
    beat_t   beat;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [2:0]  param_class_i = '0;
  logic [15:0] scalar_width_i = '0;
  logic [7:0]  slot_i = '0;
  logic        type_ends_in_star_i = 1'b0;
  logic        last_i = 1'b0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [7:0]  offset_o;
  logic        status_o;
  logic        last_result_o;

  x86_arg_stack_offset_layout_unit dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .param_class_i       (param_class_i),
    .scalar_width_i      (scalar_width_i),
    .slot_i              (slot_i),
    .type_ends_in_star_i (type_ends_in_star_i),
    .last_i              (last_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .offset_o            (offset_o),
    .status_o            (status_o),
    .last_result_o       (last_result_o)
  );

  logic [3:0]  fp_by_slot [xaso_pkg::MaxParams];
  logic [4:0]  slot_by_rec [xaso_pkg::MaxParams];
  int unsigned rec_total = 0;
  int unsigned top_slot = 0;
  bit          sig_failed = 1'b0;

  beat_t       expected_beats [$];
  row_t        directed_rows [NumRows];
  int unsigned errors = 0;
  int unsigned records_sent = 0;
  int unsigned sigs_done = 0;
  int unsigned sigs_failed = 0;
  int unsigned beats_checked = 0;
  int unsigned send_idle_pct = 13;
  int unsigned recv_idle_pct = 78;
  int unsigned hold_asks = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic void expect_beat(beat_t b);
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  function automatic logic [3:0] footprint_of(record_t r);
    case (r.cls)
      xaso_pkg::ClsFloat:  return 4'd4;
      xaso_pkg::ClsDouble: return 4'd8;
      xaso_pkg::ClsScalar: begin
        if (r.width == 16'd8) return 4'd0;
        if (r.width >= 16'd5 && r.width <= 16'd7) return 4'd8;
        return 4'd4;
      end
      xaso_pkg::ClsStructPtr: return r.star ? 4'd4 : 4'd0;
      default: return 4'd4;
    endcase
  endfunction

  function automatic void absorb_record(record_t r, bit emit);
    logic [3:0] fp;
    logic [7:0] offs [xaso_pkg::MaxParams];
    int unsigned running;
    fp = footprint_of(r);
    if (!sig_failed) begin
      if (rec_total >= xaso_pkg::MaxParams || r.slot >= xaso_pkg::MaxParams ||
          fp == 4'd0) begin
        sig_failed = 1'b1;
      end else begin
        fp_by_slot[r.slot[4:0]] = fp;
        if (r.slot > top_slot) top_slot = r.slot;
        slot_by_rec[rec_total] = r.slot[4:0];
        rec_total++;
      end
    end
    if (!r.last) return;
    sigs_done++;
    if (sig_failed) begin
      sigs_failed++;
      if (emit) expect_beat('{8'd0, 1'b1, 1'b1});
    end else begin
      running = 0;
      for (int s = 0; s <= int'(top_slot); s++) begin
        offs[s] = running[7:0];
        running += (fp_by_slot[s] != 4'd0) ? fp_by_slot[s] : xaso_pkg::StackAlign;
      end
      if (emit) begin
        for (int i = 0; i < int'(rec_total); i++)
          expect_beat('{offs[slot_by_rec[i]], 1'b0, (i + 1 == int'(rec_total))});
      end
    end
    for (int s = 0; s < int'(xaso_pkg::MaxParams); s++) fp_by_slot[s] = 4'd0;
    rec_total = 0;
    top_slot = 0;
    sig_failed = 1'b0;
  endfunction

  function automatic row_t row(logic [2:0] c, logic [15:0] w, logic [7:0] s, logic st,
                               logic l, logic typed, logic [7:0] off, logic bad);
    return '{'{c, w, s, st, l}, typed, '{off, bad, 1'b1}};
  endfunction

  function automatic record_t good_record(int n);
    record_t r;
    int unsigned top;
    top = (n + 3 < int'(xaso_pkg::MaxParams)) ? n + 3 : xaso_pkg::MaxParams - 1;
    r.cls   = 3'($urandom_range(0, 7));
    r.width = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                          : 16'($urandom_range(1, 7));
    if (r.cls == xaso_pkg::ClsScalar && r.width == 16'd8) r.width = 16'd4;
    r.star  = 1'($urandom_range(0, 1));
    if (r.cls == xaso_pkg::ClsStructPtr) r.star = 1'b1;
    r.slot  = 8'($urandom_range(0, top));
    r.last  = 1'b0;
    return r;
  endfunction

  task automatic offer_record(record_t r, bit typed, beat_t want);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    param_class_i       <= r.cls;
    scalar_width_i      <= r.width;
    slot_i              <= r.slot;
    type_ends_in_star_i <= r.star;
    last_i              <= r.last;
    in_valid_i          <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (typed) expect_beat(want);
    absorb_record(r, !typed);
    records_sent++;
  endtask

  task automatic send_signature(int n, bit broken);
    record_t r;
    int bad_at;
    int unsigned fault;
    bad_at = broken ? int'($urandom_range(0, n - 1)) : -1;
    fault  = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      r = good_record(n);
      if (i == bad_at) begin
        case (fault)
          0: r.slot = 8'($urandom_range(xaso_pkg::MaxParams, 255));
          1: begin
            r.cls   = xaso_pkg::ClsScalar;
            r.width = 16'd8;
          end
          2: begin
            r.cls  = xaso_pkg::ClsStructPtr;
            r.star = 1'b0;
          end
          default: r = record_t'(29'($urandom()));
        endcase
      end
      r.last = (i == n - 1);
      offer_record(r, 1'b0, '0);
    end
  endtask

  // receiver: random back-pressure, plus a long hold whenever one is asked for
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  always @(negedge clk_i) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_beats
    beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_checked++;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: beat with nothing expected, offset %0d status %0d last %0d",
                 $time, offset_o, status_o, last_result_o);
      end else begin
        want = expected_beats.pop_front();
        if (offset_o !== want.offset) begin
          errors++;
          $display("%0t: offset expected %0d got %0d", $time, want.offset, offset_o);
        end
        if (status_o !== want.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, status_o);
        end
        if (last_result_o !== want.last_result) begin
          errors++;
          $display("%0t: last_result expected %0d got %0d", $time, want.last_result,
                   last_result_o);
        end
      end
    end
  end

  initial begin
    int unsigned dir_end;
    bit pressured;
    for (int s = 0; s < int'(xaso_pkg::MaxParams); s++) begin
      fp_by_slot[s]  = 4'd0;
      slot_by_rec[s] = 5'd0;
    end
    directed_rows = '{
      row(xaso_pkg::ClsFloat,     16'd0,    8'd0,   1'b0, 1'b1, 1'b1, 8'd0,  1'b0),
      row(ClsHandle,              16'd0,    8'd3,   1'b0, 1'b1, 1'b1, 8'd12, 1'b0),
      row(xaso_pkg::ClsDouble,    16'd0,    8'd0,   1'b0, 1'b0, 1'b0, 8'd0,  1'b0),
      row(xaso_pkg::ClsScalar,    16'd1,    8'd1,   1'b0, 1'b0, 1'b0, 8'd0,  1'b0),
      row(xaso_pkg::ClsScalar,    16'd7,    8'd2,   1'b0, 1'b0, 1'b0, 8'd0,  1'b0),
      row(xaso_pkg::ClsScalar,    16'd0,    8'd3,   1'b0, 1'b0, 1'b0, 8'd0,  1'b0),
      row(xaso_pkg::ClsScalar,    16'hFFFF, 8'd4,   1'b0, 1'b0, 1'b0, 8'd0,  1'b0),
      row(xaso_pkg::ClsStructPtr, 16'd0,    8'd5,   1'b1, 1'b0, 1'b0, 8'd0,  1'b0),
      row(ClsHandle,              16'd0,    8'd6,   1'b1, 1'b0, 1'b0, 8'd0,  1'b0),
      row(ClsSpare,               16'hFFFF, 8'd31,  1'b1, 1'b1, 1'b0, 8'd0,  1'b0),
      row(xaso_pkg::ClsStructPtr, 16'd0,    8'd0,   1'b0, 1'b1, 1'b1, 8'd0,  1'b1),
      row(xaso_pkg::ClsScalar,    16'd8,    8'd0,   1'b0, 1'b1, 1'b1, 8'd0,  1'b1),
      row(xaso_pkg::ClsFloat,     16'd0,    8'd32,  1'b0, 1'b1, 1'b1, 8'd0,  1'b1),
      row(ClsHandle,              16'hFFFF, 8'd255, 1'b1, 1'b1, 1'b1, 8'd0,  1'b1),
      row(xaso_pkg::ClsDouble,    16'd0,    8'd2,   1'b0, 1'b0, 1'b0, 8'd0,  1'b0),
      row(xaso_pkg::ClsFloat,     16'd0,    8'd2,   1'b0, 1'b0, 1'b0, 8'd0,  1'b0),
      row(ClsSpare,               16'd0,    8'd0,   1'b0, 1'b1, 1'b0, 8'd0,  1'b0),
      row(xaso_pkg::ClsScalar,    16'd8,    8'd1,   1'b0, 1'b0, 1'b0, 8'd0,  1'b0),
      row(xaso_pkg::ClsFloat,     16'd0,    8'd0,   1'b0, 1'b1, 1'b1, 8'd0,  1'b1),
      row(xaso_pkg::ClsScalar,    16'd3,    8'd0,   1'b0, 1'b0, 1'b0, 8'd0,  1'b0),
      row(xaso_pkg::ClsScalar,    16'h00F5, 8'd1,   1'b1, 1'b1, 1'b0, 8'd0,  1'b0)
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[k])
      offer_record(directed_rows[k].rec, directed_rows[k].typed, directed_rows[k].beat);

    dir_end = records_sent;
    pressured = 1'b0;
    send_signature(xaso_pkg::MaxParams, 1'b0);
    send_signature(xaso_pkg::MaxParams + 1, 1'b0);
    while (records_sent < dir_end + RandomRecords) begin
      if (!pressured && records_sent >= dir_end + 160) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        pressured = 1'b1;
        hold_asks++;
        send_signature(xaso_pkg::MaxParams, 1'b0);
        send_signature($urandom_range(2, 6), 1'b0);
      end else begin
        if (records_sent >= dir_end + 80 && !pressured) begin
          send_idle_pct = 78;
          recv_idle_pct = 13;
        end
        case ($urandom_range(0, 19))
          0, 1:    send_signature($urandom_range(1, 8), 1'b1);
          2:       send_signature($urandom_range(9, 32), 1'b1);
          3:       send_signature($urandom_range(xaso_pkg::MaxParams + 1,
                                                 xaso_pkg::MaxParams + 4), 1'b0);
          4, 5:    send_signature($urandom_range(9, 32), 1'b0);
          default: send_signature($urandom_range(1, 8), 1'b0);
        endcase
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Covered %0d records in %0d signatures, %0d of them rejected;",
             records_sent, sigs_done, sigs_failed);
    $display("%0d result beats checked, including a long receiver hold.", beats_checked);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/xaso_pkg.sv
design/xaso_ram.sv
design/x86_arg_stack_offset_layout_unit.sv
tb/sv/x86_arg_stack_offset_layout_unit_test.sv
